// ===== rtl/matp_pkg.sv =====
// ----------------------------------------------------------------------------
// matp_pkg
// Shared codes, character constants and types for the text address parser.
// ----------------------------------------------------------------------------
package matp_pkg;

  // Parser phase codes.
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;
  localparam logic [1:0] PH_FAIL  = 2'd3;

  // Index of the last field; the body holds fields 0 through LAST_FIELD.
  localparam logic [2:0] LAST_FIELD = 3'd5;
  // Most hex digits a field may carry.
  localparam logic [1:0] MAX_DIGITS = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam int ADDR_W = 48;

  // Decoded view of one input character.
  typedef struct packed {
    logic       is_term;
    logic       is_blank;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_class_t;

  // Architectural state of the parser.
  typedef struct packed {
    logic [1:0]        phase;
    logic [2:0]        field_count;
    logic [1:0]        digit_count;
    logic [ADDR_W-1:0] acc;
  } parse_state_t;

endpackage

// ===== rtl/matp_classify.sv =====
// ----------------------------------------------------------------------------
// matp_classify
// Decodes one character into terminator, blank, colon and hex digit flags.
// ----------------------------------------------------------------------------
module matp_classify (
  input  logic [7:0]            char_code,
  output matp_pkg::char_class_t cls
);

  logic [7:0] lower;
  logic       is_dec;
  logic       is_alpha;

  // Forcing bit 5 folds upper-case letters onto lower case.
  assign lower    = char_code | 8'h20;
  assign is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_alpha = (lower >= 8'h61) && (lower <= 8'h66);

  always_comb begin
    cls.is_term  = (char_code == matp_pkg::CHAR_NUL);
    cls.is_blank = (char_code == matp_pkg::CHAR_SPACE) || (char_code == matp_pkg::CHAR_TAB);
    cls.is_colon = (char_code == matp_pkg::CHAR_COLON);
    cls.is_hex   = is_dec || is_alpha;
    // Letters a..f have low nibble 1..6, so adding nine gives 10..15.
    cls.hex_val  = is_alpha ? (char_code[3:0] + 4'd9) : char_code[3:0];
  end

endmodule

// ===== rtl/matp_step.sv =====
// ----------------------------------------------------------------------------
// matp_step
// Next-state and result logic for one character of the address text.
// ----------------------------------------------------------------------------
module matp_step (
  input  matp_pkg::char_class_t          cls,
  input  matp_pkg::parse_state_t         cur,
  output matp_pkg::parse_state_t         nxt,
  output logic [matp_pkg::ADDR_W-1:0]    res_address,
  output logic                           res_converted
);

  logic body_done;
  logic in_body;

  assign body_done = (cur.digit_count != 2'd0) && (cur.field_count == matp_pkg::LAST_FIELD);

  // A non-blank in the leading phase is the first body character.
  assign in_body = (cur.phase == matp_pkg::PH_BODY) ||
                   ((cur.phase == matp_pkg::PH_LEAD) && !cls.is_blank);

  // Result seen on a terminator.
  always_comb begin
    unique case (cur.phase)
      matp_pkg::PH_BODY:  res_converted = body_done;
      matp_pkg::PH_TRAIL: res_converted = 1'b1;
      default:            res_converted = 1'b0;
    endcase
    res_address = res_converted ? cur.acc : '0;
  end

  always_comb begin
    nxt = cur;
    if (cls.is_term) begin
      nxt = '0;
      nxt.phase = matp_pkg::PH_LEAD;
    end else if (in_body) begin
      nxt.phase = matp_pkg::PH_BODY;
      if (cls.is_blank) begin
        nxt.phase = body_done ? matp_pkg::PH_TRAIL : matp_pkg::PH_FAIL;
      end else if (cls.is_colon) begin
        if ((cur.digit_count == 2'd0) || (cur.field_count == matp_pkg::LAST_FIELD)) begin
          nxt.phase = matp_pkg::PH_FAIL;
        end else begin
          nxt.field_count = cur.field_count + 3'd1;
          nxt.digit_count = 2'd0;
        end
      end else if (!cls.is_hex || (cur.digit_count >= matp_pkg::MAX_DIGITS)) begin
        nxt.phase = matp_pkg::PH_FAIL;
      end else begin
        if (cur.digit_count == 2'd0) begin
          nxt.acc = {cur.acc[matp_pkg::ADDR_W-9:0], 4'h0, cls.hex_val};
        end else begin
          nxt.acc = {cur.acc[matp_pkg::ADDR_W-1:8], cur.acc[3:0], cls.hex_val};
        end
        nxt.digit_count = cur.digit_count + 2'd1;
      end
    end else if (cur.phase == matp_pkg::PH_TRAIL) begin
      if (!cls.is_blank) begin
        nxt.phase = matp_pkg::PH_FAIL;
      end
    end
  end

endmodule

// ===== rtl/mac_address_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// mac_address_text_parser_core
// Parses a colon-separated text Ethernet address, one character per word.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   in_     | input     | in_valid / in_ready   | in_char_code[7:0]
//   out_    | output    | out_valid / out_ready | out_address[47:0], out_converted
//
// Each character is captured in the input register; from there the decoder and
// step logic apply it to the parser state register. A
// new word is accepted in every cycle while the result path is free.
// A zero character produces one result word, loaded into the output register
// from the input register; the parser then starts over at the next word.
// A stalled result only holds back a terminator that waits behind it; other
// characters keep flowing. Reset (rst_n low, synchronous) empties both
// registers and returns the parser to its leading-blank phase.
// ----------------------------------------------------------------------------
module mac_address_text_parser_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_address,
  output logic        out_converted
);

  // Input register: one character waiting to be applied to the state.
  logic       in_vld_r;
  logic [7:0] in_char_r;

  // Parser state.
  matp_pkg::parse_state_t st_r;
  matp_pkg::parse_state_t st_nxt;

  // Output register.
  logic        out_vld_r;
  logic [47:0] out_address_r;
  logic        out_converted_r;

  matp_pkg::char_class_t cls;
  logic [47:0]           res_address;
  logic                  res_converted;
  logic                  step_go;
  logic                  term_go;

  matp_classify u_classify (
    .char_code (in_char_r),
    .cls       (cls)
  );

  matp_step u_step (
    .cls           (cls),
    .cur           (st_r),
    .nxt           (st_nxt),
    .res_address   (res_address),
    .res_converted (res_converted)
  );

  // The held character is applied unless it is a terminator and the output
  // register is full with a result that is not being taken this cycle.
  assign step_go  = in_vld_r && (!cls.is_term || !out_vld_r || out_ready);
  assign term_go  = step_go && cls.is_term;
  assign in_ready = !in_vld_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: matp_pkg::PH_LEAD, field_count: 3'd0, digit_count: 2'd0, acc: '0};
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (term_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_go) begin
      out_address_r   <= res_address;
      out_converted_r <= res_converted;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_address   = out_address_r;
  assign out_converted = out_converted_r;

  // A failed parse never reports a nonzero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_converted_r) |-> (out_address_r == 48'd0))
    else $error("failed parse reported a nonzero address");

  // A terminator returns the parser to its start state.
  a_term_reset: assert property (@(posedge clk) disable iff (!rst_n)
    term_go |=> ((st_r.phase == matp_pkg::PH_LEAD) && (st_r.field_count == 3'd0) &&
                 (st_r.digit_count == 2'd0)))
    else $error("parser state not cleared after terminator");

  // Counters stay within their legal ranges.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.digit_count <= matp_pkg::MAX_DIGITS) && (st_r.field_count <= matp_pkg::LAST_FIELD))
    else $error("field or digit count out of range");

  // A terminator blocked by a full output keeps the result pending.
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && cls.is_term && out_vld_r && !out_ready) |=> (in_vld_r && out_vld_r))
    else $error("blocked terminator or pending result lost");

endmodule
